// File: design/fmslq_pkg.sv
package fmslq_pkg;

    localparam int TABLE_SLOTS = 20;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS + 1);

    localparam int FREQ_W  = 16;
    localparam int DEV_W   = 12;
    localparam int SNR_W   = 4;
    localparam int RSSI_W  = 8;
    localparam int INDEX_W = 5;
    localparam int CFG_W   = 16;

    localparam logic [SNR_W-1:0]  SNR_MIN       = 4'd2;
    localparam logic [RSSI_W-1:0] RSSI_MIN      = 8'd10;
    localparam logic [DEV_W-1:0]  DEV_POS_LIMIT = 12'd280;
    localparam logic [DEV_W-1:0]  DEV_NEG_LIMIT = 12'd3815;
    localparam logic [DEV_W-1:0]  PREV_POS_MIN  = 12'd20;
    localparam logic [DEV_W-1:0]  PREV_NEG_MAX  = 12'd4075;

    localparam logic [FREQ_W-1:0] BAND_LOWER_RST = 16'd8750;
    localparam logic [FREQ_W-1:0] BAND_UPPER_RST = 16'd10800;

    typedef enum logic [1:0] {
        ST_CONTINUE = 2'd0,
        ST_FOUND    = 2'd1,
        ST_FULL     = 2'd2,
        ST_BAND_END = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CFG_BAND_LOWER = 2'd0,
        CFG_BAND_UPPER = 2'd1,
        CFG_AUTO_STORE = 2'd2,
        CFG_STEP_DOWN  = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [FREQ_W-1:0] frequency;
        logic [DEV_W-1:0]  deviation;
        logic [SNR_W-1:0]  snr;
        logic [RSSI_W-1:0] rssi;
        logic              afc_railed;
    } t_meas;

    typedef struct packed {
        logic              locked;
        t_status           status;
        logic [FREQ_W-1:0] next_frequency;
        logic              store_valid;
        logic [INDEX_W-1:0] store_index;
    } t_result;

    typedef struct packed {
        t_cfg_reg          index;
        logic [CFG_W-1:0]  value;
    } t_cfg_wr;

endpackage

// File: design/fmslq_meas_if.sv
interface fmslq_meas_if;
    logic              valid;
    logic              ready;
    fmslq_pkg::t_meas  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/fmslq_result_if.sv
interface fmslq_result_if;
    logic               valid;
    logic               ready;
    fmslq_pkg::t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/fmslq_cfg_if.sv
interface fmslq_cfg_if;
    logic               valid;
    logic               ready;
    fmslq_pkg::t_cfg_wr data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/fm_seek_lock_qualifier_unit.sv
// FM seek lock qualifier: takes one tuner measurement per transaction on i_meas and returns
// one result per measurement on o_result, in order. A measurement can be accepted every
// cycle while o_result is not stalled; each passes an input register and a result
// register, and a result is held in the result register on o_result for as long as
// o_result is stalled. The lock test,
// slot counter and next-frequency step all sit in the single logic stage between those
// two registers, and the previous-measurement history is updated as each result is
// registered. Configuration writes on i_cfg are always taken and must only be issued
// while no measurement is in flight; register indexes are band_lower, band_upper,
// auto_store, step_down. The slot counter saturates at the table size and only reset
// clears it.
module fm_seek_lock_qualifier_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    fmslq_meas_if.sink     i_meas,
    fmslq_cfg_if.sink      i_cfg,
    fmslq_result_if.source o_result
);
    import fmslq_pkg::*;

    logic [FREQ_W-1:0] r_band_lower;
    logic [FREQ_W-1:0] r_band_upper;
    logic              r_auto_store;
    logic              r_step_down;

    logic              r_in_valid;
    t_meas             r_meas;
    logic              r_out_valid;
    t_result           r_result;

    logic [DEV_W-1:0]  r_prev_dev;
    logic [FREQ_W-1:0] r_prev_freq;
    logic [SLOT_W-1:0] r_slot;

    logic              advance;
    logic              take;
    logic              prev_below;
    logic              prev_above;
    logic              locked;
    logic              band_end;
    logic [FREQ_W-1:0] stepped;
    logic [SLOT_W-1:0] n_slot;
    t_result           n_result;

    assign advance       = !r_out_valid || o_result.ready;
    assign take          = r_in_valid && advance;
    assign i_meas.ready  = !r_in_valid || advance;
    assign i_cfg.ready   = 1'b1;
    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_result;

    // neighbor channel checks, exact compare without 16-bit wrap
    assign prev_below = ({1'b0, r_prev_freq} + 17'd1) == {1'b0, r_meas.frequency};
    assign prev_above = {1'b0, r_prev_freq} == ({1'b0, r_meas.frequency} + 17'd1);

    always_comb begin
        locked = (r_meas.snr >= SNR_MIN) && (r_meas.rssi >= RSSI_MIN) && !r_meas.afc_railed
              && ((r_meas.deviation < DEV_POS_LIMIT) || (r_meas.deviation > DEV_NEG_LIMIT));
        if ((r_meas.frequency > r_band_lower) && prev_below) begin
            if (r_prev_dev[DEV_W-1] || (r_prev_dev < PREV_POS_MIN)) begin
                locked = 1'b0;
            end
        end
        if ((r_meas.frequency >= r_band_lower) && prev_above) begin
            if (!r_prev_dev[DEV_W-1] || (r_prev_dev > PREV_NEG_MAX)) begin
                locked = 1'b0;
            end
        end
    end

    assign band_end = r_auto_store && (r_band_upper != '0)
                   && (r_meas.frequency >= (r_band_upper - 16'd1));

    always_comb begin
        stepped = r_step_down ? (r_meas.frequency - 16'd1) : (r_meas.frequency + 16'd1);
        if (stepped < r_band_lower) begin
            stepped = r_band_upper - 16'd1;
        end else if (stepped >= r_band_upper) begin
            stepped = r_band_lower;
        end
    end

    always_comb begin
        n_slot                  = r_slot;
        n_result.locked         = locked;
        n_result.status         = ST_CONTINUE;
        n_result.next_frequency = stepped;
        n_result.store_valid    = 1'b0;
        n_result.store_index    = '0;
        if (locked && !r_auto_store) begin
            n_result.status         = ST_FOUND;
            n_result.next_frequency = r_meas.frequency;
        end else begin
            if (locked) begin
                if (r_slot < SLOT_W'(TABLE_SLOTS)) begin
                    n_result.store_valid = 1'b1;
                    n_result.store_index = INDEX_W'(r_slot);
                    n_slot               = r_slot + 1'b1;
                end
            end
            if (locked && (n_slot >= SLOT_W'(TABLE_SLOTS))) begin
                n_slot                  = SLOT_W'(TABLE_SLOTS);
                n_result.status         = ST_FULL;
                n_result.next_frequency = r_meas.frequency;
            end else if (band_end) begin
                n_result.status         = ST_BAND_END;
                n_result.next_frequency = r_meas.frequency;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band_lower <= BAND_LOWER_RST;
            r_band_upper <= BAND_UPPER_RST;
            r_auto_store <= 1'b0;
            r_step_down  <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.index)
                CFG_BAND_LOWER: r_band_lower <= i_cfg.data.value;
                CFG_BAND_UPPER: r_band_upper <= i_cfg.data.value;
                CFG_AUTO_STORE: r_auto_store <= i_cfg.data.value[0];
                CFG_STEP_DOWN:  r_step_down  <= i_cfg.data.value[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_prev_dev  <= '0;
            r_prev_freq <= '0;
            r_slot      <= '0;
        end else begin
            if (i_meas.ready) begin
                r_in_valid <= i_meas.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            // history advances only when a result is registered
            if (take) begin
                r_prev_dev  <= r_meas.deviation;
                r_prev_freq <= r_meas.frequency;
                r_slot      <= n_slot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_meas.valid && i_meas.ready) begin
            r_meas <= i_meas.data;
        end
        if (take) begin
            r_result <= n_result;
        end
    end

endmodule

// File: design/fmslq_checker.sv
module fmslq_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input fmslq_pkg::t_result  i_out_data
);
    import fmslq_pkg::*;

    // hold a stalled result transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed while stalled");

    // a store can coincide with continue, table full or band end, never with found
    a_store_locked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.store_valid |->
            i_out_data.locked && (i_out_data.status != ST_FOUND))
        else $error("store without lock or with wrong status");

    a_stop_locked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_data.status == ST_FOUND || i_out_data.status == ST_FULL)
            |-> i_out_data.locked)
        else $error("found or full without lock");

    a_index_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.store_valid |-> i_out_data.store_index == '0)
        else $error("store index set without store");

endmodule

bind fm_seek_lock_qualifier_unit fmslq_checker u_fmslq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_data  (o_result.data)
);
